// ===== sv/htc_pkg.sv =====
package htc_pkg;

    localparam int COORD_W            = 32;
    localparam int DIST_W             = 34;
    localparam int BARY_W             = 17;
    localparam int NUM_PLANES         = 6;
    localparam int MAX_POLY_VERTS     = 9;
    localparam int DEF_WEIGHT_FRAC    = 16;
    localparam int MEM_DEPTH          = 2 * MAX_POLY_VERTS;
    localparam int MEM_AW             = $clog2(MEM_DEPTH);
    localparam int CNT_W              = $clog2(MAX_POLY_VERTS + 1);

    localparam logic [2:0] PL_LEFT  = 3'd0;
    localparam logic [2:0] PL_RIGHT = 3'd1;
    localparam logic [2:0] PL_DOWN  = 3'd2;
    localparam logic [2:0] PL_UP    = 3'd3;
    localparam logic [2:0] PL_NEAR  = 3'd4;
    localparam logic [2:0] PL_FAR   = 3'd5;

    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_MID   = 2'd1;
    localparam logic [1:0] CORNER_LAST  = 2'd2;

    typedef logic [3:0][COORD_W-1:0] vert_t;

    typedef struct packed {
        logic [2:0][3:0][COORD_W-1:0] v;
        logic [NUM_PLANES-1:0]        orm;
        logic [NUM_PLANES-1:0]        andm;
    } tri_req_t;

    function automatic logic signed [DIST_W-1:0] plane_dist(input logic [2:0] p,
                                                            input vert_t c);
        logic signed [DIST_W-1:0] x, y, z, w;
        logic signed [DIST_W-1:0] d;
        x = $signed({{(DIST_W-COORD_W){c[0][COORD_W-1]}}, c[0]});
        y = $signed({{(DIST_W-COORD_W){c[1][COORD_W-1]}}, c[1]});
        z = $signed({{(DIST_W-COORD_W){c[2][COORD_W-1]}}, c[2]});
        w = $signed({{(DIST_W-COORD_W){c[3][COORD_W-1]}}, c[3]});
        case (p)
            PL_LEFT:  d = x + w;
            PL_RIGHT: d = w - x;
            PL_DOWN:  d = y + w;
            PL_UP:    d = w - y;
            PL_NEAR:  d = w - z;
            PL_FAR:   d = z + w;
            default:  d = z + w;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/htc_front.sv =====
module htc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  htc_pkg::tri_req_t   in_tri,
    output logic                req_valid,
    output htc_pkg::tri_req_t   req,
    input  logic                req_pop
);
    import htc_pkg::*;

    tri_req_t              q_reg [2];
    logic                  wptr_reg, rptr_reg;
    logic [1:0]            cnt_reg;
    logic [NUM_PLANES-1:0] codes [3];
    tri_req_t              entry;
    logic                  push;

    // outcode per vertex, distance below zero sets the bit
    always_comb begin
        for (int v = 0; v < 3; v++) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                codes[v][p] = plane_dist(3'(p), in_tri.v[v]) < 0;
            end
        end
        entry      = in_tri;
        entry.orm  = codes[0] | codes[1] | codes[2];
        entry.andm = codes[0] & codes[1] & codes[2];
    end

    assign in_ready  = cnt_reg != 2'd2;
    assign push      = in_valid && in_ready;
    assign req_valid = cnt_reg != 2'd0;
    assign req       = q_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wptr_reg] <= entry;
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= !wptr_reg;
            end
            if (req_pop) begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(req_pop);
        end
    end

endmodule

// ===== sv/htc_div.sv =====
module htc_div #(
    parameter int WF = htc_pkg::DEF_WEIGHT_FRAC
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [htc_pkg::DIST_W-1:0]    num,
    input  logic [htc_pkg::DIST_W:0]      den,
    output logic                          done,
    output logic [WF:0]                   quo
);
    import htc_pkg::*;

    localparam int QW = WF + 1;
    localparam int DW = DIST_W + 2 + WF + 1;
    localparam int RW = DIST_W + 3;
    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] dvd;
    logic [RW-1:0] rem_reg, rem_sh, den_x;
    logic [QW-1:0] low_reg, quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;

    // rounded quotient: (num * 2^WF + den / 2) / den, one bit per cycle
    assign dvd    = (DW'(num) << WF) + (DW'(den) >> 1);
    assign den_x  = RW'(den);
    assign rem_sh = {rem_reg[RW-2:0], low_reg[QW-1]};
    assign done   = done_reg;
    assign quo    = quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= RW'(dvd >> QW);
            low_reg <= dvd[QW-1:0];
        end else if (busy_reg) begin
            low_reg <= {low_reg[QW-2:0], 1'b0};
            if (rem_sh >= den_x) begin
                rem_reg <= rem_sh - den_x;
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/htc_back.sv =====
module htc_back #(
    parameter int WF = htc_pkg::DEF_WEIGHT_FRAC
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          req_valid,
    input  htc_pkg::tri_req_t             req,
    output logic                          req_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [htc_pkg::COORD_W-1:0]   out_x,
    output logic [htc_pkg::COORD_W-1:0]   out_y,
    output logic [htc_pkg::COORD_W-1:0]   out_z,
    output logic [htc_pkg::COORD_W-1:0]   out_w,
    output logic [htc_pkg::BARY_W-1:0]    bary_0,
    output logic [htc_pkg::BARY_W-1:0]    bary_1,
    output logic [htc_pkg::BARY_W-1:0]    bary_2,
    output logic [1:0]                    corner,
    output logic                          last
);
    import htc_pkg::*;

    localparam int WW  = WF + 1;
    localparam int CPW = COORD_W + WW + 1;
    localparam int WPW = 2 * WW;
    localparam logic [WW-1:0] ONE = {1'b1, {WF{1'b0}}};

    typedef struct packed {
        logic [2:0][WW-1:0]      wt;
        logic [3:0][COORD_W-1:0] c;
    } point_t;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_LOAD   = 5'd1;
    localparam logic [4:0] ST_NEXTP  = 5'd2;
    localparam logic [4:0] ST_PA     = 5'd3;
    localparam logic [4:0] ST_RDB    = 5'd4;
    localparam logic [4:0] ST_BLD    = 5'd5;
    localparam logic [4:0] ST_EVAL   = 5'd6;
    localparam logic [4:0] ST_DIV    = 5'd7;
    localparam logic [4:0] ST_MUL    = 5'd8;
    localparam logic [4:0] ST_SUM    = 5'd9;
    localparam logic [4:0] ST_KEEP   = 5'd10;
    localparam logic [4:0] ST_FSTART = 5'd11;
    localparam logic [4:0] ST_F0     = 5'd12;
    localparam logic [4:0] ST_F1     = 5'd13;
    localparam logic [4:0] ST_FV     = 5'd14;
    localparam logic [4:0] ST_O0     = 5'd15;
    localparam logic [4:0] ST_O1     = 5'd16;
    localparam logic [4:0] ST_O2     = 5'd17;

    point_t mem [MEM_DEPTH];
    point_t rdata_reg, a_reg, b_reg, s0_reg, prev_reg, cur_reg, ip, ld_pt, out_pt;

    logic [4:0]            state_reg;
    logic                  bank_reg, inb_reg, ld_last;
    logic [2:0]            pidx_reg;
    logic [1:0]            cnt_reg, ld_corner;
    logic [CNT_W-1:0]      n_reg, i_reg, m_reg, v_reg, i_next, rd_idx;
    logic [NUM_PLANES-1:0] orm_reg;
    logic [MEM_AW-1:0]     rd_addr, wr_addr;
    logic                  wr_en, keep_b, out_free, out_load;
    point_t                wr_data;

    logic signed [DIST_W-1:0] da, db;
    logic signed [DIST_W:0]   dd;
    logic [DIST_W-1:0]        div_num;
    logic [DIST_W:0]          div_den;
    logic                     div_start, div_done;
    logic [WW-1:0]            div_q, t_reg, s_w;

    logic signed [CPW-1:0] pa_reg [4];
    logic signed [CPW-1:0] pb_reg [4];
    logic [WPW-1:0]        wa_reg [3];
    logic [WPW-1:0]        wb_reg [3];

    logic                  mv_reg, ml_reg;
    logic [1:0]            mc_reg;
    point_t                mp_reg;

    function automatic logic [MEM_AW-1:0] addr_of(input logic bank,
                                                  input logic [CNT_W-1:0] idx);
        return MEM_AW'(idx) + (bank ? MEM_AW'(MAX_POLY_VERTS) : MEM_AW'(0));
    endfunction

    htc_div #(.WF(WF)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_q)
    );

    assign da      = plane_dist(pidx_reg, a_reg.c);
    assign db      = plane_dist(pidx_reg, b_reg.c);
    assign dd      = DIST_W'(0) + ($signed({da[DIST_W-1], da}) - $signed({db[DIST_W-1], db}));
    assign div_num = da[DIST_W-1] ? DIST_W'(-da) : DIST_W'(da);
    assign div_den = dd[DIST_W] ? (DIST_W+1)'(-dd) : (DIST_W+1)'(dd);
    assign s_w     = ONE - t_reg;
    assign i_next  = i_reg + 1'b1;
    assign keep_b  = inb_reg && (m_reg < CNT_W'(MAX_POLY_VERTS));
    assign out_free = !mv_reg || out_ready;

    // interpolated point, rounded half up, positions saturated
    always_comb begin
        logic signed [CPW:0]  cs, cr;
        logic [WPW:0]         ws, wr;
        for (int k = 0; k < 4; k++) begin
            cs = $signed({pa_reg[k][CPW-1], pa_reg[k]}) + $signed({pb_reg[k][CPW-1], pb_reg[k]});
            cr = (cs + (CPW+1)'(1 << (WF - 1))) >>> WF;
            if (cr > $signed({{(CPW+1-31){1'b0}}, {31{1'b1}}})) begin
                ip.c[k] = {1'b0, {(COORD_W-1){1'b1}}};
            end else if (cr < $signed({{(CPW+1-31){1'b1}}, {31{1'b0}}})) begin
                ip.c[k] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                ip.c[k] = cr[COORD_W-1:0];
            end
        end
        for (int k = 0; k < 3; k++) begin
            ws = {1'b0, wa_reg[k]} + {1'b0, wb_reg[k]};
            wr = (ws + (WPW+1)'(1 << (WF - 1))) >> WF;
            ip.wt[k] = wr[WW-1:0];
        end
    end

    always_comb begin
        ld_pt = '0;
        for (int k = 0; k < 4; k++) begin
            ld_pt.c[k] = req.v[cnt_reg][k];
        end
        for (int k = 0; k < 3; k++) begin
            ld_pt.wt[k] = (2'(k) == cnt_reg) ? ONE : '0;
        end
    end

    always_comb begin
        rd_idx    = '0;
        wr_en     = 1'b0;
        wr_addr   = addr_of(!bank_reg, m_reg);
        wr_data   = b_reg;
        div_start = 1'b0;
        out_load  = 1'b0;
        out_pt    = s0_reg;
        ld_corner = CORNER_FIRST;
        ld_last   = 1'b0;
        req_pop   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                req_pop = req_valid && (req.andm != '0);
            end
            ST_LOAD: begin
                wr_en   = 1'b1;
                wr_addr = addr_of(1'b0, CNT_W'(cnt_reg));
                wr_data = ld_pt;
                req_pop = cnt_reg == 2'd2;
            end
            ST_RDB: begin
                rd_idx = (i_next == n_reg) ? '0 : i_next;
            end
            ST_EVAL: begin
                div_start = (da > 0) != (db > 0);
            end
            ST_SUM: begin
                wr_en   = m_reg < CNT_W'(MAX_POLY_VERTS);
                wr_data = ip;
            end
            ST_KEEP: begin
                wr_en = keep_b;
            end
            ST_F0: begin
                rd_idx = CNT_W'(1);
            end
            ST_F1: begin
                rd_idx = CNT_W'(2);
            end
            ST_O0: begin
                out_load = out_free;
            end
            ST_O1: begin
                out_load  = out_free;
                out_pt    = prev_reg;
                ld_corner = CORNER_MID;
            end
            ST_O2: begin
                out_load  = out_free;
                out_pt    = cur_reg;
                ld_corner = CORNER_LAST;
                ld_last   = v_reg == n_reg - 1'b1;
                rd_idx    = v_reg + 1'b1;
            end
            default: begin
                rd_idx = '0;
            end
        endcase
        rd_addr = addr_of(bank_reg, rd_idx);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            for (int k = 0; k < 4; k++) begin
                pa_reg[k] <= $signed(a_reg.c[k]) * $signed({1'b0, s_w});
                pb_reg[k] <= $signed(b_reg.c[k]) * $signed({1'b0, t_reg});
            end
            for (int k = 0; k < 3; k++) begin
                wa_reg[k] <= a_reg.wt[k] * s_w;
                wb_reg[k] <= b_reg.wt[k] * t_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            mp_reg <= out_pt;
            mc_reg <= ld_corner;
            ml_reg <= ld_last;
        end
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (out_load) begin
            mv_reg <= 1'b1;
        end else if (out_ready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bank_reg  <= 1'b0;
            pidx_reg  <= '0;
            cnt_reg   <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            m_reg     <= '0;
            v_reg     <= '0;
            orm_reg   <= '0;
            inb_reg   <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (req_valid && req.andm == '0) begin
                        orm_reg   <= req.orm;
                        cnt_reg   <= '0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 2'd2) begin
                        bank_reg  <= 1'b0;
                        n_reg     <= CNT_W'(3);
                        pidx_reg  <= '0;
                        state_reg <= ST_NEXTP;
                    end
                end
                ST_NEXTP: begin
                    if (pidx_reg == 3'(NUM_PLANES)) begin
                        state_reg <= ST_FSTART;
                    end else if (!orm_reg[pidx_reg] || n_reg == '0) begin
                        pidx_reg <= pidx_reg + 1'b1;
                    end else begin
                        i_reg     <= '0;
                        m_reg     <= '0;
                        state_reg <= ST_PA;
                    end
                end
                ST_PA: begin
                    a_reg     <= rdata_reg;
                    state_reg <= ST_RDB;
                end
                ST_RDB: begin
                    state_reg <= ST_BLD;
                end
                ST_BLD: begin
                    b_reg     <= rdata_reg;
                    state_reg <= ST_EVAL;
                end
                ST_EVAL: begin
                    inb_reg   <= db > 0;
                    state_reg <= div_start ? ST_DIV : ST_KEEP;
                end
                ST_DIV: begin
                    if (div_done) begin
                        t_reg     <= div_q;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    if (m_reg < CNT_W'(MAX_POLY_VERTS)) begin
                        m_reg <= m_reg + 1'b1;
                    end
                    state_reg <= ST_KEEP;
                end
                ST_KEEP: begin
                    a_reg <= b_reg;
                    i_reg <= i_next;
                    if (i_next == n_reg) begin
                        n_reg     <= m_reg + CNT_W'(keep_b);
                        bank_reg  <= !bank_reg;
                        pidx_reg  <= pidx_reg + 1'b1;
                        state_reg <= ST_NEXTP;
                    end else begin
                        m_reg     <= m_reg + CNT_W'(keep_b);
                        state_reg <= ST_RDB;
                    end
                end
                ST_FSTART: begin
                    state_reg <= (n_reg < CNT_W'(3)) ? ST_IDLE : ST_F0;
                end
                ST_F0: begin
                    s0_reg    <= rdata_reg;
                    state_reg <= ST_F1;
                end
                ST_F1: begin
                    prev_reg  <= rdata_reg;
                    v_reg     <= CNT_W'(2);
                    state_reg <= ST_FV;
                end
                ST_FV: begin
                    cur_reg   <= rdata_reg;
                    state_reg <= ST_O0;
                end
                ST_O0: begin
                    if (out_free) begin
                        state_reg <= ST_O1;
                    end
                end
                ST_O1: begin
                    if (out_free) begin
                        state_reg <= ST_O2;
                    end
                end
                ST_O2: begin
                    if (out_free) begin
                        if (ld_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            prev_reg  <= cur_reg;
                            v_reg     <= v_reg + 1'b1;
                            state_reg <= ST_FV;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = mv_reg;
    assign out_x     = mp_reg.c[0];
    assign out_y     = mp_reg.c[1];
    assign out_z     = mp_reg.c[2];
    assign out_w     = mp_reg.c[3];
    assign bary_0    = BARY_W'(mp_reg.wt[0]);
    assign bary_1    = BARY_W'(mp_reg.wt[1]);
    assign bary_2    = BARY_W'(mp_reg.wt[2]);
    assign corner    = mc_reg;
    assign last      = ml_reg;

endmodule

// ===== sv/homogeneous_triangle_clipper.sv =====
// Homogeneous triangle clipper.
// Input channel (s_): one triangle request, three clip-space vertices, each
// x, y, z, w in signed Q16.16. Output channel (m_): one vertex per request,
// with its position, barycentric weights of the input vertices, its corner
// within the output triangle and last on the final vertex of a triangle.
// Triangles fully inside come out as three vertices, fully outside as none,
// otherwise the clipped polygon is fan-triangulated.
// Operation: each clip pass walks every polygon edge, and each crossing waits
// on the bit-serial divider that computes the crossing parameter; the fan
// vertices are then emitted in turn, with each further fan vertex fetched from
// memory before its triangle goes out.
// The front classifies requests and holds up to two in a queue, so s_ready
// stays high while the back is busy until that queue is full.
// Reset (aresetn low, synchronous) empties the queue and the output register.
// When m_ready is low the pending vertex holds in the output register and the
// clipper waits; the front keeps accepting until its queue fills.
module homogeneous_triangle_clipper #(
    parameter int WEIGHT_FRAC_BITS = htc_pkg::DEF_WEIGHT_FRAC
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [htc_pkg::COORD_W-1:0]   s_v0_x,
    input  logic [htc_pkg::COORD_W-1:0]   s_v0_y,
    input  logic [htc_pkg::COORD_W-1:0]   s_v0_z,
    input  logic [htc_pkg::COORD_W-1:0]   s_v0_w,
    input  logic [htc_pkg::COORD_W-1:0]   s_v1_x,
    input  logic [htc_pkg::COORD_W-1:0]   s_v1_y,
    input  logic [htc_pkg::COORD_W-1:0]   s_v1_z,
    input  logic [htc_pkg::COORD_W-1:0]   s_v1_w,
    input  logic [htc_pkg::COORD_W-1:0]   s_v2_x,
    input  logic [htc_pkg::COORD_W-1:0]   s_v2_y,
    input  logic [htc_pkg::COORD_W-1:0]   s_v2_z,
    input  logic [htc_pkg::COORD_W-1:0]   s_v2_w,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [htc_pkg::COORD_W-1:0]   m_out_x,
    output logic [htc_pkg::COORD_W-1:0]   m_out_y,
    output logic [htc_pkg::COORD_W-1:0]   m_out_z,
    output logic [htc_pkg::COORD_W-1:0]   m_out_w,
    output logic [htc_pkg::BARY_W-1:0]    m_bary_0,
    output logic [htc_pkg::BARY_W-1:0]    m_bary_1,
    output logic [htc_pkg::BARY_W-1:0]    m_bary_2,
    output logic [1:0]                    m_corner,
    output logic                          m_last
);
    import htc_pkg::*;

    tri_req_t in_tri, req;
    logic     req_valid, req_pop;

    always_comb begin
        in_tri      = '0;
        in_tri.v[0] = {s_v0_w, s_v0_z, s_v0_y, s_v0_x};
        in_tri.v[1] = {s_v1_w, s_v1_z, s_v1_y, s_v1_x};
        in_tri.v[2] = {s_v2_w, s_v2_z, s_v2_y, s_v2_x};
    end

    htc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_tri    (in_tri),
        .req_valid (req_valid),
        .req       (req),
        .req_pop   (req_pop)
    );

    htc_back #(.WF(WEIGHT_FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req       (req),
        .req_pop   (req_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_x     (m_out_x),
        .out_y     (m_out_y),
        .out_z     (m_out_z),
        .out_w     (m_out_w),
        .bary_0    (m_bary_0),
        .bary_1    (m_bary_1),
        .bary_2    (m_bary_2),
        .corner    (m_corner),
        .last      (m_last)
    );

    a_last_on_corner2: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_corner == CORNER_LAST)
        else $error("last flagged away from third corner");

    a_corner_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_corner != 2'd3)
        else $error("corner out of range");

    a_pop_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        req_pop |-> req_valid)
        else $error("queue popped while empty");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import htc_pkg::*;

    localparam int WFRAC = DEF_WEIGHT_FRAC;
    localparam longint WONE = longint'(1) << WFRAC;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        longint c[4];
        longint wt[3];
    } clip_pt_t;

    typedef struct {
        logic [COORD_W-1:0] x, y, z, w;
        logic [BARY_W-1:0]  b0, b1, b2;
        logic [1:0]         corner;
        logic               last;
    } vtx_out_t;

    typedef logic [COORD_W-1:0] tri_in_t [12];

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [COORD_W-1:0] s_f [12];
    logic m_valid;
    logic m_ready = 1'b0;
    logic [COORD_W-1:0] m_out_x, m_out_y, m_out_z, m_out_w;
    logic [BARY_W-1:0]  m_bary_0, m_bary_1, m_bary_2;
    logic [1:0]         m_corner;
    logic               m_last;

    int errors = 0;
    int cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;
    bit hold_recv = 1'b0;

    initial for (int i = 0; i < 12; i++) s_f[i] = '0;

    always #5 aclk = ~aclk;

    homogeneous_triangle_clipper i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_v0_x(s_f[0]), .s_v0_y(s_f[1]), .s_v0_z(s_f[2]), .s_v0_w(s_f[3]),
        .s_v1_x(s_f[4]), .s_v1_y(s_f[5]), .s_v1_z(s_f[6]), .s_v1_w(s_f[7]),
        .s_v2_x(s_f[8]), .s_v2_y(s_f[9]), .s_v2_z(s_f[10]), .s_v2_w(s_f[11]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z), .m_out_w(m_out_w),
        .m_bary_0(m_bary_0), .m_bary_1(m_bary_1), .m_bary_2(m_bary_2),
        .m_corner(m_corner), .m_last(m_last)
    );

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint plane_distance(int p, clip_pt_t q);
        case (p)
            PL_LEFT:  return q.c[0] + q.c[3];
            PL_RIGHT: return q.c[3] - q.c[0];
            PL_DOWN:  return q.c[1] + q.c[3];
            PL_UP:    return q.c[3] - q.c[1];
            PL_NEAR:  return q.c[3] - q.c[2];
            default:  return q.c[2] + q.c[3];
        endcase
    endfunction

    function automatic longint round_weight(longint s);
        longint bias;
        longint u;
        bias = longint'(1) << 62;
        u = s + bias + (longint'(1) << (WFRAC - 1));
        return (u >>> WFRAC) - (bias >>> WFRAC);
    endfunction

    function automatic longint sat_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic clip_pt_t crossing(clip_pt_t a, clip_pt_t b, longint da, longint db);
        clip_pt_t o;
        longint num, den, t, s;
        num = da < 0 ? -da : da;
        den = (da - db) < 0 ? db - da : da - db;
        t = ((num << WFRAC) + den / 2) / den;
        s = WONE - t;
        for (int k = 0; k < 4; k++) o.c[k] = sat_coord(round_weight(a.c[k] * s + b.c[k] * t));
        for (int k = 0; k < 3; k++) o.wt[k] = round_weight(a.wt[k] * s + b.wt[k] * t);
        return o;
    endfunction

    function automatic vtx_out_t pack_vtx(clip_pt_t p, int corner, bit last);
        vtx_out_t r;
        r.x = p.c[0][31:0];
        r.y = p.c[1][31:0];
        r.z = p.c[2][31:0];
        r.w = p.c[3][31:0];
        r.b0 = p.wt[0][16:0];
        r.b1 = p.wt[1][16:0];
        r.b2 = p.wt[2][16:0];
        r.corner = corner[1:0];
        r.last = last;
        return r;
    endfunction

    class clip_scoreboard;
        vtx_out_t expected_vtx[$];

        function void note_request(tri_in_t t);
            clip_pt_t src[$];
            clip_pt_t dst[$];
            int codes[3];
            int orm, andm, n;
            for (int v = 0; v < 3; v++) begin
                clip_pt_t q;
                for (int k = 0; k < 4; k++) q.c[k] = longint'($signed(t[v*4+k]));
                for (int k = 0; k < 3; k++) q.wt[k] = (k == v) ? WONE : 0;
                codes[v] = 0;
                for (int p = 0; p < NUM_PLANES; p++)
                    if (plane_distance(p, q) < 0) codes[v] |= 1 << p;
                src = {src, q};
            end
            orm = codes[0] | codes[1] | codes[2];
            andm = codes[0] & codes[1] & codes[2];
            if (orm == 0) begin
                for (int v = 0; v < 3; v++)
                    expected_vtx = {expected_vtx, pack_vtx(src[v], v, v == 2)};
                return;
            end
            if (andm != 0) return;
            for (int p = 0; p < NUM_PLANES; p++) begin
                if (orm & (1 << p)) begin
                    n = src.size();
                    dst = {};
                    for (int i = 0; i < n; i++) begin
                        clip_pt_t a, b;
                        longint da, db;
                        a = src[i];
                        b = src[(i + 1 == n) ? 0 : i + 1];
                        da = plane_distance(p, a);
                        db = plane_distance(p, b);
                        if ((da > 0) != (db > 0) && dst.size() < MAX_POLY_VERTS)
                            dst = {dst, crossing(a, b, da, db)};
                        if (db > 0 && dst.size() < MAX_POLY_VERTS) dst = {dst, b};
                    end
                    src = dst;
                end
            end
            n = src.size();
            for (int v = 2; v < n; v++) begin
                expected_vtx = {expected_vtx, pack_vtx(src[0], CORNER_FIRST, 1'b0)};
                expected_vtx = {expected_vtx, pack_vtx(src[v-1], CORNER_MID, 1'b0)};
                expected_vtx = {expected_vtx, pack_vtx(src[v], CORNER_LAST, v == n - 1)};
            end
        endfunction

        task check_vertex(vtx_out_t g);
            vtx_out_t e;
            if (expected_vtx.size() == 0) begin
                report("unexpected vertex", g.x, 0);
                return;
            end
            e = expected_vtx.pop_front();
            if (g.x !== e.x) report("out_x", $signed(g.x), $signed(e.x));
            if (g.y !== e.y) report("out_y", $signed(g.y), $signed(e.y));
            if (g.z !== e.z) report("out_z", $signed(g.z), $signed(e.z));
            if (g.w !== e.w) report("out_w", $signed(g.w), $signed(e.w));
            if (g.b0 !== e.b0) report("bary_0", g.b0, e.b0);
            if (g.b1 !== e.b1) report("bary_1", g.b1, e.b1);
            if (g.b2 !== e.b2) report("bary_2", g.b2, e.b2);
            if (g.corner !== e.corner) report("corner", g.corner, e.corner);
            if (g.last !== e.last) report("last", g.last, e.last);
        endtask
    endclass

    clip_scoreboard sb = new();

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("homogeneous_triangle_clipper test failed");
            $finish;
        end
        if (aresetn && s_valid && s_ready) sb.note_request(s_f);
        if (aresetn && m_valid && m_ready) begin
            vtx_out_t g;
            g.x = m_out_x; g.y = m_out_y; g.z = m_out_z; g.w = m_out_w;
            g.b0 = m_bary_0; g.b1 = m_bary_1; g.b2 = m_bary_2;
            g.corner = m_corner; g.last = m_last;
            sb.check_vertex(g);
        end
    end

    // receiver readiness
    always @(negedge aclk) begin
        if (hold_recv) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_triangle(input tri_in_t t);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        for (int i = 0; i < 12; i++) s_f[i] <= t[i];
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_coord(int mag);
        int v;
        v = $urandom_range(2 * mag) - mag;
        return v;
    endfunction

    // mostly partially clipped triangles with w between 0.5 and 3.0
    function automatic tri_in_t rand_triangle();
        tri_in_t t;
        int kind;
        kind = $urandom_range(9);
        for (int v = 0; v < 3; v++) begin
            if (kind == 0) begin
                for (int k = 0; k < 4; k++) t[v*4+k] = $urandom();
            end else begin
                int wv;
                wv = $urandom_range(32'h30000, 32'h8000);
                for (int k = 0; k < 3; k++)
                    t[v*4+k] = rand_coord(kind < 3 ? wv : 3 * wv);
                t[v*4+3] = wv;
                if (kind == 9) begin
                    t[v*4+0] = ($urandom_range(1)) ? wv : -wv;
                end
            end
        end
        return t;
    endfunction

    function automatic tri_in_t make_tri(int a0, a1, a2, a3, b0, b1, b2, b3,
                                         c0, c1, c2, c3);
        tri_in_t t;
        t = '{a0, a1, a2, a3, b0, b1, b2, b3, c0, c1, c2, c3};
        return t;
    endfunction

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (sb.expected_vtx.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    localparam int ONE = 32'h10000;

    initial begin
        tri_in_t t;
        send_idle = 20;
        recv_idle = 72;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: accept, reject, each plane, zero distance, extremes
        send_triangle(make_tri(0, 0, 0, ONE, ONE/2, 0, 0, ONE, 0, ONE/2, 0, ONE));
        send_triangle(make_tri(3*ONE, 0, 0, ONE, 4*ONE, ONE, 0, ONE, 5*ONE, 0, 0, ONE));
        send_triangle(make_tri(-2*ONE, 0, 0, ONE, ONE/2, 0, 0, ONE, 0, ONE/2, 0, ONE));
        send_triangle(make_tri(2*ONE, 0, 0, ONE, -ONE/2, 0, 0, ONE, 0, ONE/2, 0, ONE));
        send_triangle(make_tri(0, -2*ONE, 0, ONE, ONE/2, 0, 0, ONE, 0, ONE/2, 0, ONE));
        send_triangle(make_tri(0, 2*ONE, 0, ONE, ONE/2, 0, 0, ONE, 0, -ONE/2, 0, ONE));
        send_triangle(make_tri(0, 0, 2*ONE, ONE, ONE/2, 0, 0, ONE, 0, ONE/2, 0, ONE));
        send_triangle(make_tri(0, 0, -2*ONE, ONE, ONE/2, 0, 0, ONE, 0, ONE/2, 0, ONE));
        send_triangle(make_tri(-3*ONE, -3*ONE, 0, ONE, 3*ONE, -3*ONE, 2*ONE, ONE,
                               0, 3*ONE, -2*ONE, ONE));
        send_triangle(make_tri(ONE, 0, 0, ONE, 2*ONE, ONE, 0, ONE, 0, 0, 0, ONE));
        send_triangle(make_tri(ONE, 0, 0, ONE, ONE, ONE, 0, ONE, ONE, -ONE, 0, ONE));
        send_triangle(make_tri(0, 0, 0, 0, ONE, 0, 0, ONE, 0, ONE, 0, ONE));
        send_triangle(make_tri(32'h7fffffff, 0, 0, 32'h7fffffff, 32'h80000000, 0, 0,
                               32'h7fffffff, 0, 32'h80000000, 0, 32'h7fffffff));
        send_triangle(make_tri(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                               32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                               0, 0, 0, 32'h7fffffff));
        send_triangle(make_tri(-1, -1, -1, -1, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h80000000, 5, 5, 5, 5));
        send_triangle(make_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                               32'h7fffffff, 0, 0, 32'h7fffffff, -1, -1, 0, 1));
        send_triangle(make_tri(-ONE, -ONE, -ONE, ONE, ONE, ONE, ONE, ONE, -ONE, ONE, 0, ONE));

        for (int i = 0; i < 113; i++) begin
            if (i == 28) begin
                wait_drain();
                send_idle = 72;
                recv_idle = 20;
            end
            if (i == 73) begin
                wait_drain();
                send_idle = 0;
                recv_idle = 0;
            end
            if (i == 83) begin
                fork
                    begin
                        hold_recv = 1'b1;
                        repeat (600) @(posedge aclk);
                        hold_recv = 1'b0;
                    end
                join_none
            end
            send_triangle(rand_triangle());
        end

        fork
            wait_drain();
        join
        if (errors == 0 && sb.expected_vtx.size() == 0) begin
            $display("homogeneous_triangle_clipper test passed");
        end else begin
            if (sb.expected_vtx.size() != 0)
                report("vertices never emitted", sb.expected_vtx.size(), 0);
            $display("homogeneous_triangle_clipper test failed");
        end
        $finish;
    end
endmodule
